### design/dmm_pkg.sv
// Shared constants, request codes and control structs for the dense matrix multiply core.
// Depends on nothing; every other file of the block imports it.
package dmm_pkg;

  localparam int MAX_DIM  = 32;
  localparam int IDX_W    = $clog2(MAX_DIM);
  localparam int ADDR_W   = 2 * IDX_W;
  localparam int DEPTH    = MAX_DIM * MAX_DIM;
  localparam int SIZE_W   = 6;
  localparam int ELEM_W   = 16;
  localparam int PROD_W   = 2 * ELEM_W;
  localparam int ACC_W    = 40;
  localparam int REQ_W    = 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(32);
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_DIM);

  typedef enum logic [REQ_W-1:0] {
    REQ_WR_A    = 2'd0,
    REQ_WR_B    = 2'd1,
    REQ_COMPUTE = 2'd2,
    REQ_NONE    = 2'd3
  } req_type_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             rd_en;
    logic             acc_clr;
    logic             emit;
    logic             last;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
  } dmm_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } dmm_stat_t;

endpackage

### design/dmm_if.sv
// Valid/ready channel interfaces for request items and result items.
// Depends on dmm_pkg for the field widths.
interface dmm_req_if;
  import dmm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic [IDX_W-1:0]        row;
  logic [IDX_W-1:0]        col;
  logic signed [ELEM_W-1:0] value;

  modport source (output valid, req_type, row, col, value, input ready);
  modport sink   (input valid, req_type, row, col, value, output ready);
endinterface

interface dmm_res_if;
  import dmm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        out_row;
  logic [IDX_W-1:0]        out_col;
  logic signed [ACC_W-1:0] product_value;
  logic                    last;

  modport source (output valid, out_row, out_col, product_value, last, input ready);
  modport sink   (input valid, out_row, out_col, product_value, last, output ready);
endinterface

### design/dmm_ctrl.sv
// Sequencer of the matrix multiply core: size register, request decode, row/column/k loops.
// Depends on dmm_pkg; drives the datapath through dmm_cmd_t and reads dmm_stat_t.
module dmm_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [dmm_pkg::SIZE_W-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [dmm_pkg::REQ_W-1:0]  in_req_type,
  input  logic [dmm_pkg::IDX_W-1:0]  in_row,
  output dmm_pkg::dmm_cmd_t          cmd,
  input  dmm_pkg::dmm_stat_t         stat
);
  import dmm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MAC   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic [SIZE_W-1:0] matrix_size;
  logic [IDX_W-1:0]  n_last;
  logic [IDX_W-1:0]  i, i_next;
  logic [IDX_W-1:0]  j, j_next;
  logic [IDX_W-1:0]  k, k_next;
  logic              accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= SIZE_RESET;
    end else if (cfg_we) begin
      matrix_size <= cfg_wdata;
    end
  end

  // Index of the last row/column in use, with the size clamped to 1..MAX_DIM.
  always_comb begin
    if (matrix_size == '0) begin
      n_last = '0;
    end else if (matrix_size > SIZE_MAX) begin
      n_last = IDX_W'(MAX_DIM - 1);
    end else begin
      n_last = IDX_W'(matrix_size - SIZE_W'(1));
    end
  end

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next  = state;
    i_next      = i;
    j_next      = j;
    k_next      = k;
    cmd         = '0;
    cmd.i       = i;
    cmd.j       = j;
    cmd.k       = k;
    cmd.last    = (j == n_last);
    case (state)
      S_IDLE: begin
        if (accept) begin
          // Row and column fields cannot reach MAX_DIM, so every write lands.
          case (req_type_t'(in_req_type))
            REQ_WR_A: cmd.wr_a = 1'b1;
            REQ_WR_B: cmd.wr_b = 1'b1;
            REQ_COMPUTE: begin
              if (in_row <= n_last) begin
                i_next      = in_row;
                j_next      = '0;
                k_next      = '0;
                cmd.acc_clr = 1'b1;
                state_next  = S_MAC;
              end
            end
            default: ;
          endcase
        end
      end
      S_MAC: begin
        cmd.rd_en = 1'b1;
        if (k == n_last) begin
          k_next     = '0;
          state_next = S_DRAIN;
        end else begin
          k_next = k + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (j == n_last) begin
            state_next = S_IDLE;
          end else begin
            j_next     = j + IDX_W'(1);
            state_next = S_MAC;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      i     <= '0;
      j     <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
      k     <= k_next;
    end
  end

endmodule

### design/dmm_datapath.sv
// Datapath of the matrix multiply core: A and B stores, one multiplier, accumulator, result register.
// Depends on dmm_pkg; obeys dmm_cmd_t from the controller and reports dmm_stat_t.
module dmm_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  dmm_pkg::dmm_cmd_t                  cmd,
  output dmm_pkg::dmm_stat_t                 stat,
  input  logic [dmm_pkg::IDX_W-1:0]          in_row,
  input  logic [dmm_pkg::IDX_W-1:0]          in_col,
  input  logic signed [dmm_pkg::ELEM_W-1:0]  in_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [dmm_pkg::IDX_W-1:0]          out_row,
  output logic [dmm_pkg::IDX_W-1:0]          out_col,
  output logic signed [dmm_pkg::ACC_W-1:0]   out_value,
  output logic                               out_last
);
  import dmm_pkg::*;

  logic signed [ELEM_W-1:0] left_mem  [DEPTH];
  logic signed [ELEM_W-1:0] right_mem [DEPTH];

  logic [ADDR_W-1:0]        wr_addr;
  logic [ADDR_W-1:0]        a_addr;
  logic [ADDR_W-1:0]        b_addr;
  logic signed [ELEM_W-1:0] a_q;
  logic signed [ELEM_W-1:0] b_q;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic                     rd_vld;
  logic                     prod_vld;

  assign wr_addr = {in_row, in_col};
  assign a_addr  = {cmd.i, cmd.k};
  assign b_addr  = {cmd.k, cmd.j};

  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      left_mem[wr_addr] <= in_value;
    end
    if (cmd.wr_b) begin
      right_mem[wr_addr] <= in_value;
    end
    if (cmd.rd_en) begin
      a_q <= left_mem[a_addr];
      b_q <= right_mem[b_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld) begin
      prod <= a_q * b_q;
    end
    if (cmd.acc_clr || cmd.emit) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld   <= 1'b0;
      prod_vld <= 1'b0;
    end else begin
      rd_vld   <= cmd.rd_en;
      prod_vld <= rd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_row   <= cmd.i;
      out_col   <= cmd.j;
      out_value <= acc;
      out_last  <= cmd.last;
    end
  end

  assign stat.pipe_busy = rd_vld || prod_vld;
  assign stat.out_free  = !out_valid || out_ready;

endmodule

### design/dense_matrix_multiply_core.sv
// Top level of the dense matrix multiply core: controller, datapath and channel wiring.
// Depends on dmm_pkg, the channel interfaces in dmm_if.sv, dmm_ctrl and dmm_datapath.
//
//   Channel   Direction  Handshake        Carries
//   in_ch     sink       valid / ready    req_type, row, col, value
//   out_ch    source     valid / ready    out_row, out_col, product_value, last
//   cfg       sink       cfg_we only      cfg_wdata -> matrix_size
//
// A write item of A or B produces nothing. A compute item for a row of an n by n
// product works through the columns in turn: each column streams n reads through
// the single multiplier, waits for the read, multiply and accumulate stages to
// drain, then hands its result to the output register.
// The block takes no new item until the whole row has been issued. A stalled
// result holds in the output register; the next column waits only for that slot.
// Reset (rst, synchronous) sets matrix_size to 32 and clears control state; the
// A and B stores are not cleared and must be written before they are read.

module dense_matrix_multiply_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [dmm_pkg::SIZE_W-1:0] cfg_wdata,
  dmm_req_if.sink                    in_ch,
  dmm_res_if.source                  out_ch
);
  import dmm_pkg::*;

  dmm_cmd_t  cmd;
  dmm_stat_t stat;

  // The controller owns the request handshake and sequencing of all loops.
  dmm_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_req_type (in_ch.req_type),
    .in_row      (in_ch.row),
    .cmd         (cmd),
    .stat        (stat)
  );

  // The datapath holds both stores, the multiply-accumulate pipe and the result register.
  dmm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_row    (in_ch.row),
    .in_col    (in_ch.col),
    .in_value  (in_ch.value),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_row   (out_ch.out_row),
    .out_col   (out_ch.out_col),
    .out_value (out_ch.product_value),
    .out_last  (out_ch.last)
  );

  // A result is only loaded when the output register can take it.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("result loaded while output register occupied");

  // A loaded result is presented on the next cycle.
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_ch.valid)
    else $error("loaded result not presented");

  // The pipe has drained whenever a new request item can be taken.
  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !stat.pipe_busy)
    else $error("request accepted while multiply pipe still busy");

  // Store writes and reads never share a cycle.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> !(cmd.wr_a || cmd.wr_b))
    else $error("store write during compute read");

endmodule

### test/tb_dense_matrix_multiply_core.sv
// Self-checking testbench for dense_matrix_multiply_core: loads A and B elements, requests
// rows of C at many matrix sizes and checks every result element against a running model.
// Depends on dmm_pkg, the channel interfaces in dmm_if.sv and the core itself.
module tb_dense_matrix_multiply_core;
  import dmm_pkg::*;

  // The quietest correct stretch is the settle time at the full size or the long output
  // hold below; the watchdog allows several times that.
  localparam int QUIET_LIMIT = 6000;
  localparam int LONG_HOLD   = 300;

  // One request item as the driver presents it.
  typedef struct {
    req_type_t               kind;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [ELEM_W-1:0] value;
  } mm_req_t;

  // One element of C as the core should deliver it.
  typedef struct {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [ACC_W-1:0] sum;
    logic                    last;
  } c_elem_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [SIZE_W-1:0] cfg_wdata;

  dmm_req_if req_ch ();
  dmm_res_if res_ch ();

  dense_matrix_multiply_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (req_ch),
    .out_ch    (res_ch)
  );

  // Shadow copy of the two element stores and the size register, updated as items are
  // accepted. The stores are never cleared, matching the core.
  logic signed [ELEM_W-1:0] a_store [MAX_DIM][MAX_DIM];
  logic signed [ELEM_W-1:0] b_store [MAX_DIM][MAX_DIM];
  logic [SIZE_W-1:0]        size_reg = SIZE_RESET;

  // Which entries the stimulus has already queued a write for. A row of C is only
  // requested once every A and B entry it reads is covered here.
  bit a_loaded [MAX_DIM][MAX_DIM];
  bit b_loaded [MAX_DIM][MAX_DIM];

  mm_req_t req_backlog [$];
  c_elem_t c_row_due [$];

  int errors       = 0;
  int items_taken  = 0;
  int elems_seen   = 0;
  int sizes_run    = 0;

  // Driver and receiver pacing.
  int      send_gap   = 0;
  bit      send_calm  = 0;
  int      recv_wait  = 0;
  bit      recv_calm  = 0;
  int      hold_left  = 0;
  bit      held_once  = 0;
  int      quiet      = 0;
  mm_req_t took;
  mm_req_t nxt;
  c_elem_t want;

  // Clock: period 10, starting low.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The size the core actually uses: zero behaves as one, anything above MAX_DIM as MAX_DIM.
  function automatic int size_in_use(logic [SIZE_W-1:0] v);
    if (v == 0) return 1;
    if (v > SIZE_MAX) return MAX_DIM;
    return int'(v);
  endfunction

  // Applies one accepted item to the shadow stores. A compute of a row inside the current
  // size produces that whole row of C, column by column, with last on the final column.
  // Rows at or beyond the size, and the unused request code, produce nothing.
  task automatic shadow_matrix_op(input mm_req_t r);
    int n;
    logic signed [ACC_W-1:0] acc;
    c_elem_t e;
    case (r.kind)
      REQ_WR_A: a_store[r.row][r.col] = r.value;
      REQ_WR_B: b_store[r.row][r.col] = r.value;
      REQ_COMPUTE: begin
        n = size_in_use(size_reg);
        if (int'(r.row) < n) begin
          for (int j = 0; j < n; j++) begin
            acc = '0;
            // All operands are signed, so each element is sign-extended to 40 bits
            // before the multiply; the sum cannot overflow at this width.
            for (int k = 0; k < n; k++) acc = acc + a_store[r.row][k] * b_store[k][j];
            e.row  = r.row;
            e.col  = IDX_W'(j);
            e.sum  = acc;
            e.last = (j == n - 1);
            c_row_due.push_back(e);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Element values lean on the two extremes and zero so that sign handling and the
  // largest products show up often.
  function automatic logic signed [ELEM_W-1:0] pick_elem();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  task automatic queue_bare(input req_type_t kind, input int row, input int col,
                            input logic signed [ELEM_W-1:0] value);
    mm_req_t r;
    r.kind  = kind;
    r.row   = IDX_W'(row);
    r.col   = IDX_W'(col);
    r.value = value;
    req_backlog.push_back(r);
  endtask

  task automatic queue_write(input req_type_t kind, input int row, input int col,
                             input logic signed [ELEM_W-1:0] value);
    queue_bare(kind, row, col, value);
    if (kind == REQ_WR_A) a_loaded[row][col] = 1'b1;
    else b_loaded[row][col] = 1'b1;
  endtask

  // Requests row i of C at size n, first loading any A or B entry the row would read
  // that has never been written. The ignored col and value fields get random bits.
  task automatic queue_row_compute(input int i, input int n);
    for (int k = 0; k < n; k++)
      if (!a_loaded[i][k]) queue_write(REQ_WR_A, i, k, pick_elem());
    for (int k = 0; k < n; k++)
      for (int j = 0; j < n; j++)
        if (!b_loaded[k][j]) queue_write(REQ_WR_B, k, j, pick_elem());
    queue_bare(REQ_COMPUTE, i, $urandom, ELEM_W'($urandom));
  endtask

  // Waits until every item has gone in and every due element has come out, then lets
  // the core finish any row sweep that produces nothing.
  task automatic wait_idle();
    int settle;
    do @(negedge clk);
    while (req_backlog.size() != 0 || req_ch.valid || c_row_due.size() != 0);
    settle = size_in_use(size_reg);
    settle = settle * (settle + 4) + 20;
    repeat (settle) @(posedge clk);
  endtask

  // Size writes happen only with the core idle.
  task automatic set_size(input logic [SIZE_W-1:0] v);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    size_reg   = v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sizes_run++;
  endtask

  // Mostly well-formed traffic: element writes inside the size and row computes with
  // their inputs loaded. The rest is writes beyond the size, computes of rows outside
  // it, and the unused request code. At the full size a row would read all of B, so
  // there only writes anywhere in the stores and the unused code go in.
  task automatic run_random_phase(input int count, input int n);
    int pick;
    for (int t = 0; t < count; t++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)
        queue_write($urandom_range(0, 1) ? REQ_WR_B : REQ_WR_A, $urandom_range(0, n - 1),
                    $urandom_range(0, n - 1), pick_elem());
      else if (pick < 50 || (n == MAX_DIM && pick < 92))
        queue_write($urandom_range(0, 1) ? REQ_WR_B : REQ_WR_A,
                    $urandom_range(0, MAX_DIM - 1), $urandom_range(0, MAX_DIM - 1),
                    pick_elem());
      else if (n < MAX_DIM && pick < 85)
        queue_row_compute($urandom_range(0, n - 1), n);
      else if (n < MAX_DIM && pick < 92)
        queue_bare(REQ_COMPUTE, $urandom_range(n, MAX_DIM - 1), $urandom, ELEM_W'($urandom));
      else
        queue_bare(REQ_NONE, $urandom, $urandom, ELEM_W'($urandom));
    end
  endtask

  // Request driver. Each item is held until accepted, then the next one follows after
  // its own drawn gap. Calm stretches send back to back.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        took.kind  = req_type_t'(req_ch.req_type);
        took.row   = req_ch.row;
        took.col   = req_ch.col;
        took.value = req_ch.value;
        shadow_matrix_op(took);
        items_taken++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_ch.valid <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          nxt = req_backlog.pop_front();
          req_ch.req_type <= nxt.kind;
          req_ch.row      <= nxt.row;
          req_ch.col      <= nxt.col;
          req_ch.value    <= nxt.value;
          req_ch.valid    <= 1'b1;
          if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
          send_gap = send_calm ? 0 : $urandom_range(0, 5);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver. Every accepted element is compared with the oldest one
  // due. Once, in the middle of a row and with more items waiting, the receiver holds
  // off for a long stretch so that the output register fills and the core stops taking
  // requests while the driver keeps offering them.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      recv_wait = 0;
      hold_left = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        elems_seen++;
        if (c_row_due.size() == 0) begin
          errors++;
          $display("%0t: C element row %0d col %0d value %0d arrived with nothing due",
                   $time, res_ch.out_row, res_ch.out_col, res_ch.product_value);
        end else begin
          want = c_row_due.pop_front();
          if (res_ch.out_row !== want.row) begin
            errors++;
            $display("%0t: out_row expected %0d actual %0d", $time, want.row, res_ch.out_row);
          end
          if (res_ch.out_col !== want.col) begin
            errors++;
            $display("%0t: out_col expected %0d actual %0d", $time, want.col, res_ch.out_col);
          end
          if (res_ch.product_value !== want.sum) begin
            errors++;
            $display("%0t: product_value (row %0d col %0d) expected %0d actual %0d",
                     $time, want.row, want.col, want.sum, res_ch.product_value);
          end
          if (res_ch.last !== want.last) begin
            errors++;
            $display("%0t: last (row %0d col %0d) expected %0b actual %0b",
                     $time, want.row, want.col, want.last, res_ch.last);
          end
        end
        if (!held_once && !res_ch.last && req_backlog.size() > 3) begin
          held_once = 1'b1;
          hold_left = LONG_HOLD;
        end else begin
          if ($urandom_range(0, 15) == 0) recv_calm = !recv_calm;
          recv_wait = recv_calm ? 0 : $urandom_range(0, 5);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: any accepted item or size write counts as progress.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: timeout, no item moved for %0d cycles, %0d C elements still due",
                 $time, QUIET_LIMIT, c_row_due.size());
        $display("tb_dense_matrix_multiply_core failed");
        $finish;
      end
    end
  end

  initial begin
    int sweep [10] = '{1, 2, 3, 5, 8, 63, 4, 7, 6, 2};
    int n;

    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_NONE;
    req_ch.row      = '0;
    req_ch.col      = '0;
    req_ch.value    = '0;
    res_ch.ready    = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // At the reset size of 32 a row of C reads every entry of B, far more writes than
    // this run sends, so only corner writes of the two extreme elements go in here.
    queue_write(REQ_WR_A, 0, 0, 16'h8000);
    queue_write(REQ_WR_B, 0, 0, 16'h8000);
    queue_write(REQ_WR_A, 31, 31, 16'h7fff);
    queue_write(REQ_WR_B, 31, 31, 16'h7fff);

    // A size of zero behaves as a 1 by 1 product. Only row 0 returns anything; writes far
    // outside the size are still stored, and the unused request code is dropped.
    set_size(6'd0);
    queue_write(REQ_WR_A, 0, 0, 16'h8000);
    queue_write(REQ_WR_B, 0, 0, 16'h8000);
    queue_bare(REQ_COMPUTE, 0, 31, 16'hffff);
    queue_write(REQ_WR_A, 0, 0, 16'h7fff);
    queue_bare(REQ_COMPUTE, 0, 0, 16'h0000);
    queue_bare(REQ_COMPUTE, 1, 0, 16'h0000);
    queue_bare(REQ_COMPUTE, 31, 31, 16'h7fff);
    queue_bare(REQ_NONE, 31, 31, 16'hffff);
    queue_write(REQ_WR_A, 31, 31, 16'h7fff);
    queue_write(REQ_WR_B, 31, 31, 16'h8000);

    // A 2 by 2 product with mixed signs; row 2 lies outside and returns nothing.
    set_size(6'd2);
    queue_write(REQ_WR_A, 0, 1, 16'hffff);
    queue_write(REQ_WR_A, 1, 0, 16'h0100);
    queue_write(REQ_WR_A, 1, 1, 16'h8000);
    queue_write(REQ_WR_B, 0, 1, 16'h7fff);
    queue_write(REQ_WR_B, 1, 0, 16'h0001);
    queue_write(REQ_WR_B, 1, 1, 16'h8000);
    queue_bare(REQ_COMPUTE, 0, 0, 16'h0000);
    queue_bare(REQ_COMPUTE, 1, 0, 16'h0000);
    queue_bare(REQ_COMPUTE, 2, 0, 16'h0000);

    // Random traffic over a sweep of sizes, including 63, which acts as the maximum.
    foreach (sweep[p]) begin
      set_size(SIZE_W'(sweep[p]));
      n = size_in_use(SIZE_W'(sweep[p]));
      run_random_phase(9, n);
    end

    wait_idle();
    if (c_row_due.size() != 0) errors++;

    $display("Ran %0d request items through %0d size settings plus the reset size,",
             items_taken, sizes_run);
    $display("checking %0d elements of C with %0d mismatches.", elems_seen, errors);
    if (errors == 0) begin
      $display("tb_dense_matrix_multiply_core passed");
    end else begin
      $display("tb_dense_matrix_multiply_core failed");
    end
    $finish;
  end

endmodule
